// ===== hdl/range_frame_decoder_averager_assert.svh =====
// assertion macros for the range frame decoder averager checker
// used by rfda_checker, no other dependencies
`ifndef RANGE_FRAME_DECODER_AVERAGER_ASSERT_SVH
`define RANGE_FRAME_DECODER_AVERAGER_ASSERT_SVH

// same-cycle implication
`define RFDA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfda assertion failed");

// next-cycle implication
`define RFDA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfda assertion failed");

`endif

// ===== hdl/rfda_pkg.sv =====
// shared types and constants for the range frame decoder averager
// no dependencies
`default_nettype none

package rfda_pkg;

    localparam logic [7:0]  HEADER_BYTE       = 8'h54;
    localparam logic [7:0]  CRC_POLY          = 8'h07;
    localparam logic [7:0]  STATUS_FAULT_BITS = 8'h1F;
    localparam logic [15:0] ERROR_DISTANCE    = 16'h0001;
    localparam logic [15:0] LIMIT_MM          = 16'd30000;
    localparam logic [15:0] BASE_MAX_CM       = 16'd3000;
    localparam logic [15:0] MARGIN_CM         = 16'd1000;
    localparam logic [14:0] USER_MAX_RESET    = 15'd3000;

    localparam int USER_MAX_BITS = 15;
    localparam int DIST_MM_BITS  = 19;
    localparam int OUT_DATA_BITS = 24;
    localparam int APB_ADDR_BITS = 3;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // register index (paddr[2])
    localparam logic REG_USER_MAX = 1'b0;

    localparam logic [2:0] POS_HUNT   = 3'd0;
    localparam logic [2:0] POS_DIST_H = 3'd1;
    localparam logic [2:0] POS_DIST_L = 3'd2;
    localparam logic [2:0] POS_STATUS = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PARSE,
        ST_CRC,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

`default_nettype wire

// ===== hdl/range_frame_decoder_averager.sv =====
// Rangefinder frame decoder and averager. Each input transaction carries one received
// serial byte (tuser low) or a report request (tuser high). Bytes are assembled into
// five-byte frames (header 0x54, distance high, distance low, status, crc-8) and checked
// frames are summed; a report returns the truncated average in mm, the out-of-range
// substitute max(3000, user max + 1000) cm in mm, or a not-valid result, and clears
// the sums. The header and the three data bytes each go through the bit-serial crc
// unit stepping one bit per cycle; a non-header byte while hunting and the check
// byte return to idle straight from parsing. A report with readings goes through the
// restoring divider producing one quotient bit per cycle; a report with no readings
// goes straight to loading the result. Bytes keep being taken while a report
// result waits on the output register, but a further report holds the input until
// that result has been taken.
// depends on rfda_pkg, rfda_crc, rfda_div
`default_nettype none

module range_frame_decoder_averager
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // data_byte
    input  wire logic                                s_tuser,   // command
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // reading_valid, out_of_range, distance_mm[18:0], zero pad
    output logic [rfda_pkg::OUT_DATA_BITS-1:0]       m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rfda_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    localparam int SUM_BITS = COUNT_BITS + 15;
    localparam int PAD_BITS = rfda_pkg::OUT_DATA_BITS - rfda_pkg::DIST_MM_BITS - 2;

    rfda_pkg::state_t       state_reg;
    rfda_pkg::state_t       state_next;
    logic [2:0]             pos_reg;
    logic [2:0]             pos_next;
    logic [7:0]             run_crc_reg;
    logic [7:0]             run_crc_next;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   bad_reg;
    logic                   bad_next;
    logic [14:0]            user_max_reg;
    logic [14:0]            user_max_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   cmd_reg;
    logic                   cmd_next;
    logic [7:0]             byte_reg;
    logic [7:0]             byte_next;
    logic [7:0]             dist_h_reg;
    logic [7:0]             dist_h_next;
    logic [7:0]             dist_l_reg;
    logic [7:0]             dist_l_next;
    logic [7:0]             status_reg;
    logic [7:0]             status_next;
    logic                   out_rv_reg;
    logic                   out_rv_next;
    logic                   out_oor_reg;
    logic                   out_oor_next;
    logic [18:0]            out_mm_reg;
    logic [18:0]            out_mm_next;

    rfda_pkg::unit_status_t crc_status;
    rfda_pkg::unit_status_t div_status;
    logic                   crc_start;
    logic [7:0]             crc_seed;
    logic [7:0]             crc_value;
    logic                   div_start;
    logic [SUM_BITS-1:0]    quotient;

    logic                   accept;
    logic                   out_free;
    logic                   cfg_write;
    logic [15:0]            frame_mm;
    logic                   frame_bad;
    logic [15:0]            oor_cm;
    logic [19:0]            oor_mm;

    rfda_crc u_crc
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (crc_start),
        .seed   (crc_seed),
        .data   (byte_reg),
        .status (crc_status),
        .crc    (crc_value)
    );

    rfda_div
    #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == rfda_pkg::REG_USER_MAX) ? {17'd0, user_max_reg} : 32'd0;

    assign s_tready = (state_reg == rfda_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, out_mm_reg, out_oor_reg, out_rv_reg};

    assign frame_mm  = {dist_h_reg, dist_l_reg};
    assign frame_bad = (frame_mm >= rfda_pkg::LIMIT_MM)
                    || ((status_reg & rfda_pkg::STATUS_FAULT_BITS) != 8'd0)
                    || (frame_mm == rfda_pkg::ERROR_DISTANCE);
    assign crc_seed  = (pos_reg == rfda_pkg::POS_HUNT) ? 8'd0 : run_crc_reg;

    always_comb
    begin
        oor_cm = {1'b0, user_max_reg} + rfda_pkg::MARGIN_CM;
        if (oor_cm < rfda_pkg::BASE_MAX_CM)
        begin
            oor_cm = rfda_pkg::BASE_MAX_CM;
        end
        oor_mm = {1'b0, oor_cm, 3'b000} + {3'b000, oor_cm, 1'b0};
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        run_crc_next   = run_crc_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        bad_next       = bad_reg;
        user_max_next  = user_max_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        dist_h_next    = dist_h_reg;
        dist_l_next    = dist_l_reg;
        status_next    = status_reg;
        out_rv_next    = out_rv_reg;
        out_oor_next   = out_oor_reg;
        out_mm_next    = out_mm_reg;
        crc_start      = 1'b0;
        div_start      = 1'b0;

        if (cfg_write && (paddr[2] == rfda_pkg::REG_USER_MAX))
        begin
            user_max_next = pwdata[rfda_pkg::USER_MAX_BITS-1:0];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rfda_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = s_tuser;
                    byte_next  = s_tdata;
                    state_next = rfda_pkg::ST_PARSE;
                end
            end
            rfda_pkg::ST_PARSE:
            begin
                if (cmd_reg == rfda_pkg::CMD_REPORT)
                begin
                    if (count_reg != '0)
                    begin
                        div_start  = 1'b1;
                        state_next = rfda_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = rfda_pkg::ST_LOAD;
                    end
                end
                else
                begin
                    unique case (pos_reg)
                        rfda_pkg::POS_HUNT:
                        begin
                            if (byte_reg == rfda_pkg::HEADER_BYTE)
                            begin
                                crc_start  = 1'b1;
                                pos_next   = rfda_pkg::POS_DIST_H;
                                state_next = rfda_pkg::ST_CRC;
                            end
                            else
                            begin
                                state_next = rfda_pkg::ST_IDLE;
                            end
                        end
                        rfda_pkg::POS_DIST_H:
                        begin
                            dist_h_next = byte_reg;
                            crc_start   = 1'b1;
                            pos_next    = rfda_pkg::POS_DIST_L;
                            state_next  = rfda_pkg::ST_CRC;
                        end
                        rfda_pkg::POS_DIST_L:
                        begin
                            dist_l_next = byte_reg;
                            crc_start   = 1'b1;
                            pos_next    = rfda_pkg::POS_STATUS;
                            state_next  = rfda_pkg::ST_CRC;
                        end
                        rfda_pkg::POS_STATUS:
                        begin
                            status_next = byte_reg;
                            crc_start   = 1'b1;
                            pos_next    = 3'(rfda_pkg::POS_STATUS + 3'd1);
                            state_next  = rfda_pkg::ST_CRC;
                        end
                        default:
                        begin
                            // check byte
                            if (byte_reg == run_crc_reg)
                            begin
                                if (frame_bad)
                                begin
                                    bad_next = 1'b1;
                                end
                                else if (count_reg != {COUNT_BITS{1'b1}})
                                begin
                                    sum_next   = sum_reg + SUM_BITS'(frame_mm);
                                    count_next = count_reg + COUNT_BITS'(1);
                                end
                            end
                            pos_next     = rfda_pkg::POS_HUNT;
                            run_crc_next = 8'd0;
                            state_next   = rfda_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rfda_pkg::ST_CRC:
            begin
                if (crc_status.done)
                begin
                    run_crc_next = crc_value;
                    state_next   = rfda_pkg::ST_IDLE;
                end
            end
            rfda_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = rfda_pkg::ST_LOAD;
                end
            end
            rfda_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg != '0)
                    begin
                        out_rv_next  = 1'b1;
                        out_oor_next = 1'b0;
                        out_mm_next  = quotient[rfda_pkg::DIST_MM_BITS-1:0];
                    end
                    else if (bad_reg)
                    begin
                        out_rv_next  = 1'b1;
                        out_oor_next = 1'b1;
                        out_mm_next  = oor_mm[rfda_pkg::DIST_MM_BITS-1:0];
                    end
                    else
                    begin
                        out_rv_next  = 1'b0;
                        out_oor_next = 1'b0;
                        out_mm_next  = '0;
                    end
                    sum_next   = '0;
                    count_next = '0;
                    bad_next   = 1'b0;
                    state_next = rfda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfda_pkg::ST_IDLE;
            pos_reg       <= rfda_pkg::POS_HUNT;
            run_crc_reg   <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            bad_reg       <= 1'b0;
            user_max_reg  <= rfda_pkg::USER_MAX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            run_crc_reg   <= run_crc_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            bad_reg       <= bad_next;
            user_max_reg  <= user_max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        byte_reg    <= byte_next;
        dist_h_reg  <= dist_h_next;
        dist_l_reg  <= dist_l_next;
        status_reg  <= status_next;
        out_rv_reg  <= out_rv_next;
        out_oor_reg <= out_oor_next;
        out_mm_reg  <= out_mm_next;
    end

endmodule

`default_nettype wire

// ===== hdl/rfda_crc.sv =====
// bit-serial crc-8 unit, one polynomial step per cycle
// depends on rfda_pkg
`default_nettype none

module rfda_crc
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [7:0]           seed,
    input  wire logic [7:0]           data,
    output rfda_pkg::unit_status_t    status,
    output logic      [7:0]           crc
);

    localparam logic [2:0] LAST_STEP = 3'd7;

    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       busy_reg;
    logic       busy_next;
    logic       done_reg;
    logic       done_next;
    logic [7:0] shifted;

    always_comb
    begin
        shifted   = crc_reg[7] ? ({crc_reg[6:0], 1'b0} ^ rfda_pkg::CRC_POLY)
                               : {crc_reg[6:0], 1'b0};
        crc_next  = crc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            crc_next  = seed ^ data;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next = shifted;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign crc         = crc_reg;

endmodule

`default_nettype wire

// ===== hdl/rfda_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on rfda_pkg
`default_nettype none

module rfda_div
#(
    parameter int DIVIDEND_BITS = 31,
    parameter int DIVISOR_BITS  = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output rfda_pkg::unit_status_t        status,
    output logic      [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_BITS - 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVIDEND_BITS-1:0] quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVISOR_BITS-1:0]  den_reg;
    logic [DIVISOR_BITS-1:0]  den_next;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [CNT_BITS-1:0]      cnt_next;
    logic                     busy_reg;
    logic                     busy_next;
    logic                     done_reg;
    logic                     done_next;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS+1:0]  diff;
    logic                     fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        fits      = !diff[DIVISOR_BITS+1];
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/rfda_checker.sv =====
// port-level checks for the range frame decoder averager, bound to the top level
// depends on range_frame_decoder_averager_assert.svh
`default_nettype none

`include "range_frame_decoder_averager_assert.svh"

module rfda_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    `RFDA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RFDA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `RFDA_ASSERT_NOW(a_oor_is_valid, clk, rst_n, m_tvalid && m_tdata[1], m_tdata[0])
    `RFDA_ASSERT_NOW(a_avg_in_limit, clk, rst_n, m_tvalid && m_tdata[0] && !m_tdata[1], m_tdata[20:2] < 19'd30000)

endmodule

bind range_frame_decoder_averager rfda_checker u_rfda_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
